// ===== design/b32enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b32enc_pkg: shared types and constants for the Bech32 address encoder
// Sequencer states, checksum unit commands, BCH polymod step and alphabet.
// ----------------------------------------------------------------------------
package b32enc_pkg;

  // Checksum residue width and digit width
  localparam int unsigned CHK_W   = 30;
  localparam int unsigned DIGIT_W = 5;
  localparam int unsigned CHAR_W  = 7;

  // BCH generator terms, one per bit of the outgoing digit
  localparam logic [CHK_W-1:0] GEN0 = 30'h3b6a57b2;
  localparam logic [CHK_W-1:0] GEN1 = 30'h26508e6d;
  localparam logic [CHK_W-1:0] GEN2 = 30'h1ea119fa;
  localparam logic [CHK_W-1:0] GEN3 = 30'h3d4233dd;
  localparam logic [CHK_W-1:0] GEN4 = 30'h2a1462b3;

  // Residue value after reset and at the start of every address
  localparam logic [CHK_W-1:0] CHK_INIT_VAL = 30'd1;

  // Character set, first character in the top byte
  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  localparam logic [CHAR_W-1:0] SEP_CHAR = 7'h31;  // '1'

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_HRP_HI,
    S_HRP_MID,
    S_HRP_LO,
    S_SEP,
    S_VER,
    S_DATA,
    S_FIN,
    S_CHK
  } state_t;

  // Checksum unit operations
  typedef enum logic [1:0] {
    CHK_HOLD,
    CHK_INIT,
    CHK_STEP,
    CHK_SHIFT
  } chk_op_t;

  typedef struct packed {
    chk_op_t              op;
    logic [DIGIT_W-1:0]   val;
  } chk_cmd_t;

  // One polymod step: shift residue by one digit, fold the top digit back
  function automatic logic [CHK_W-1:0] poly_step(input logic [CHK_W-1:0] r);
    logic [DIGIT_W-1:0] top;
    logic [CHK_W-1:0]   x;
    top = r[CHK_W-1 -: DIGIT_W];
    x   = {r[CHK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    if (top[0]) x = x ^ GEN0;
    if (top[1]) x = x ^ GEN1;
    if (top[2]) x = x ^ GEN2;
    if (top[3]) x = x ^ GEN3;
    if (top[4]) x = x ^ GEN4;
    return x;
  endfunction

  // Map a 5-bit value to its ASCII character
  function automatic logic [CHAR_W-1:0] b32_char(input logic [DIGIT_W-1:0] v);
    logic [7:0] pos;
    pos = {~v, 3'b000};
    return ALPHABET[pos +: CHAR_W];
  endfunction

endpackage

// ===== design/b32enc_chk.sv =====
// ----------------------------------------------------------------------------
// b32enc_chk: checksum residue unit
// Holds the 30-bit polymod residue; steps it one digit per cycle while commanded,
// and shifts the finished checksum out most significant digit first.
// ----------------------------------------------------------------------------
module b32enc_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  b32enc_pkg::chk_cmd_t              cmd,
  output logic [b32enc_pkg::DIGIT_W-1:0]    top_digit
);

  logic [b32enc_pkg::CHK_W-1:0] res_r;
  logic [b32enc_pkg::CHK_W-1:0] res_nxt;

  // Residue update
  always_comb begin
    res_nxt = res_r;
    unique case (cmd.op)
      b32enc_pkg::CHK_HOLD:  res_nxt = res_r;
      b32enc_pkg::CHK_INIT:  res_nxt = b32enc_pkg::CHK_INIT_VAL;
      b32enc_pkg::CHK_STEP:  res_nxt = b32enc_pkg::poly_step(res_r) ^
                                       {{(b32enc_pkg::CHK_W-b32enc_pkg::DIGIT_W){1'b0}},
                                        cmd.val};
      b32enc_pkg::CHK_SHIFT: res_nxt = {res_r[b32enc_pkg::CHK_W-b32enc_pkg::DIGIT_W-1:0],
                                        {b32enc_pkg::DIGIT_W{1'b0}}};
      default:               res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= b32enc_pkg::CHK_INIT_VAL;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign top_digit = res_r[b32enc_pkg::CHK_W-1 -: b32enc_pkg::DIGIT_W];

endmodule

// ===== design/bech32_address_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// bech32_address_encoder_unit: witness version 0 Bech32 address encoder
// Streams witness program bytes in and address characters out.
// ----------------------------------------------------------------------------
// Takes one program byte per input transfer and works on it alone until all
// its characters are sent; in_tready is high only in the idle state. A middle
// byte sends one or two characters. The first byte of an address also sends
// the prefix (L = prefix length after saturation): L high-bit steps, one
// separator step, L prefix characters, '1' and 'q'. The last byte adds up to
// one pad character, six finishing polymod steps and six checksum characters.
// A full output register stalls the sequencer in its character states until
// its transfer completes.
// ----------------------------------------------------------------------------
module bech32_address_encoder_unit #(
  parameter int unsigned MAX_PREFIX_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  // program byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] prog_byte
  input  logic        in_tlast,   // last_byte
  // address character stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] out_char, [7] zero
  output logic        out_tlast   // last_char
);

  localparam logic       REG_PREFIX_CHARS  = 1'b0;
  localparam logic       REG_PREFIX_LENGTH = 1'b1;
  localparam logic [3:0] MAX_LEN           = 4'(MAX_PREFIX_CHARS);

  // Configuration registers
  logic [63:0] prefix_chars_r;
  logic [3:0]  prefix_length_r;

  // Sequencer state
  b32enc_pkg::state_t state_r, state_nxt;
  logic [2:0]  idx_r, idx_nxt;      // prefix character index
  logic [2:0]  step_r, step_nxt;    // finishing step / checksum digit count
  logic [11:0] buf_r, buf_nxt;      // pending program bits, left aligned
  logic [3:0]  cnt_r, cnt_nxt;      // number of pending bits
  logic        last_r, last_nxt;
  logic        in_msg_r, in_msg_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [b32enc_pkg::CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                              out_last_r, out_last_nxt;

  b32enc_pkg::chk_cmd_t              chk_cmd;
  logic [b32enc_pkg::DIGIT_W-1:0]    chk_top;

  logic        in_xfer;
  logic        out_free;
  logic [3:0]  len_sat;
  logic        idx_end;
  logic [7:0]  hrp_byte;
  logic        data_emit;
  logic        emit;
  logic [b32enc_pkg::CHAR_W-1:0] emit_char;
  logic        emit_last;

  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign len_sat   = (prefix_length_r > MAX_LEN) ? MAX_LEN : prefix_length_r;
  assign idx_end   = ({1'b0, idx_r} == (len_sat - 4'd1));
  assign hrp_byte  = prefix_chars_r[{idx_r, 3'b000} +: 8];
  assign data_emit = (cnt_r >= 4'd5) || (last_r && (cnt_r != 4'd0));
  assign in_tready = (state_r == b32enc_pkg::S_IDLE);

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_chars_r  <= 64'h6362;
      prefix_length_r <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PREFIX_CHARS:  prefix_chars_r  <= cfg_wdata;
        REG_PREFIX_LENGTH: prefix_length_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b32enc_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_msg_r)               state_nxt = b32enc_pkg::S_DATA;
          else if (len_sat == 4'd0)   state_nxt = b32enc_pkg::S_HRP_MID;
          else                        state_nxt = b32enc_pkg::S_HRP_HI;
        end
      end
      b32enc_pkg::S_HRP_HI: begin
        if (idx_end) state_nxt = b32enc_pkg::S_HRP_MID;
      end
      b32enc_pkg::S_HRP_MID: begin
        state_nxt = (len_sat == 4'd0) ? b32enc_pkg::S_SEP : b32enc_pkg::S_HRP_LO;
      end
      b32enc_pkg::S_HRP_LO: begin
        if (out_free && idx_end) state_nxt = b32enc_pkg::S_SEP;
      end
      b32enc_pkg::S_SEP: begin
        if (out_free) state_nxt = b32enc_pkg::S_VER;
      end
      b32enc_pkg::S_VER: begin
        if (out_free) state_nxt = b32enc_pkg::S_DATA;
      end
      b32enc_pkg::S_DATA: begin
        if (!data_emit) state_nxt = last_r ? b32enc_pkg::S_FIN : b32enc_pkg::S_IDLE;
      end
      b32enc_pkg::S_FIN: begin
        if (step_r == 3'd5) state_nxt = b32enc_pkg::S_CHK;
      end
      b32enc_pkg::S_CHK: begin
        if (out_free && (step_r == 3'd5)) state_nxt = b32enc_pkg::S_IDLE;
      end
      default: state_nxt = b32enc_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs of each state
  always_comb begin
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    in_msg_nxt  = in_msg_r;
    chk_cmd.op  = b32enc_pkg::CHK_HOLD;
    chk_cmd.val = '0;
    emit        = 1'b0;
    emit_char   = '0;
    emit_last   = 1'b0;
    unique case (state_r)
      b32enc_pkg::S_IDLE: begin
        if (in_xfer) begin
          // merge the new byte below the pending bits
          buf_nxt  = buf_r | ({in_tdata, 4'b0000} >> cnt_r);
          cnt_nxt  = cnt_r + 4'd8;
          last_nxt = in_tlast;
          idx_nxt  = '0;
        end
      end
      b32enc_pkg::S_HRP_HI: begin
        chk_cmd.op  = b32enc_pkg::CHK_STEP;
        chk_cmd.val = {2'b00, hrp_byte[7:5]};
        idx_nxt     = idx_end ? 3'd0 : idx_r + 3'd1;
      end
      b32enc_pkg::S_HRP_MID: begin
        chk_cmd.op = b32enc_pkg::CHK_STEP;
      end
      b32enc_pkg::S_HRP_LO: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_char   = hrp_byte[6:0];
          chk_cmd.op  = b32enc_pkg::CHK_STEP;
          chk_cmd.val = hrp_byte[4:0];
          idx_nxt     = idx_end ? 3'd0 : idx_r + 3'd1;
        end
      end
      b32enc_pkg::S_SEP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32enc_pkg::SEP_CHAR;
        end
      end
      b32enc_pkg::S_VER: begin
        // version 0
        if (out_free) begin
          emit       = 1'b1;
          emit_char  = b32enc_pkg::b32_char(5'd0);
          chk_cmd.op = b32enc_pkg::CHK_STEP;
          in_msg_nxt = 1'b1;
        end
      end
      b32enc_pkg::S_DATA: begin
        // one 5-bit digit from the top of the bit buffer, zero padded
        if (data_emit) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_char   = b32enc_pkg::b32_char(buf_r[11:7]);
            chk_cmd.op  = b32enc_pkg::CHK_STEP;
            chk_cmd.val = buf_r[11:7];
            buf_nxt     = {buf_r[6:0], 5'b00000};
            cnt_nxt     = (cnt_r >= 4'd5) ? cnt_r - 4'd5 : 4'd0;
          end
        end else begin
          step_nxt = '0;
        end
      end
      b32enc_pkg::S_FIN: begin
        // six zero steps; the last one also applies the final xor with 1
        chk_cmd.op  = b32enc_pkg::CHK_STEP;
        chk_cmd.val = (step_r == 3'd5) ? 5'd1 : 5'd0;
        step_nxt    = (step_r == 3'd5) ? 3'd0 : step_r + 3'd1;
      end
      b32enc_pkg::S_CHK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32enc_pkg::b32_char(chk_top);
          emit_last = (step_r == 3'd5);
          if (step_r == 3'd5) begin
            chk_cmd.op = b32enc_pkg::CHK_INIT;
            step_nxt   = '0;
            buf_nxt    = '0;
            cnt_nxt    = '0;
            last_nxt   = 1'b0;
            in_msg_nxt = 1'b0;
          end else begin
            chk_cmd.op = b32enc_pkg::CHK_SHIFT;
            step_nxt   = step_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register load
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b32enc_pkg::S_IDLE;
      idx_r       <= '0;
      step_r      <= '0;
      buf_r       <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  b32enc_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (chk_cmd),
    .top_digit (chk_top)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== tb/tb_bech32_address_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bech32_address_encoder_unit: self-checking bench for the address encoder
// Streams witness program bytes through the encoder and checks every address
// character against a cycle-free predictor of prefix, data and checksum.
// ----------------------------------------------------------------------------
// A short directed table covers the byte extremes, single-byte addresses, a
// zero-length and an over-long prefix, prefix bytes with bit 7 set or zero, a
// prefix rewrite in the middle of an address and a message that leaves no pad
// bits. Random addresses follow in three phases of sender and receiver stalls,
// with random prefixes written between addresses and one long receiver
// hold-off that backs the encoder up into its input.
// ----------------------------------------------------------------------------
module tb_bech32_address_encoder_unit;

  localparam int unsigned PFX_MAX     = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 460;

  // Configuration register indexes
  localparam logic REG_PREFIX_CHARS  = 1'b0;
  localparam logic REG_PREFIX_LENGTH = 1'b1;

  // Data character set, character of digit 0 in the top byte
  localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef enum logic {
    ROW_WRITE,
    ROW_BYTE
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        idx;
    logic [63:0] data;
    logic        lst;
    logic        has_lead;
    logic [6:0]  lead;
  } dir_row_t;

  typedef struct {
    logic [6:0] ch;
    logic       lst;
  } addr_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // Predictor state and configuration
  logic [63:0] pfx_chars;
  logic [3:0]  pfx_len;
  logic [11:0] acc;
  int unsigned nbits;
  logic [29:0] residue;
  logic        msg_open;

  addr_char_t  addr_char_q[$];
  dir_row_t    dir_tbl[$];

  // Typed first character for the next address, applied by the predictor
  logic        lead_pending;
  logic [6:0]  lead_ch;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_left;
  int unsigned sent_items;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  bech32_address_encoder_unit #(
    .MAX_PREFIX_CHARS(PFX_MAX)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] prog_byte
    .in_tlast  (in_tlast),   // last_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [6:0] out_char, [7] zero
    .out_tlast (out_tlast)   // last_char
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached", $time);
      $display("bech32_address_encoder_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One BCH polymod step over a 30-bit residue
  function automatic logic [29:0] bch_step(input logic [29:0] r);
    logic [4:0]  top;
    logic [29:0] x;
    top = r[29:25];
    x   = {r[24:0], 5'd0};
    if (top[0]) x = x ^ 30'h3b6a57b2;
    if (top[1]) x = x ^ 30'h26508e6d;
    if (top[2]) x = x ^ 30'h1ea119fa;
    if (top[3]) x = x ^ 30'h3d4233dd;
    if (top[4]) x = x ^ 30'h2a1462b3;
    return x;
  endfunction

  function automatic logic [6:0] digit_to_char(input logic [4:0] v);
    return CHARSET[(31 - v) * 8 +: 7];
  endfunction

  task automatic push_addr_char(input logic [6:0] ch, input logic lst);
    addr_char_t e;
    e.ch  = ch;
    e.lst = lst;
    if (lead_pending) begin
      e.ch         = lead_ch;
      lead_pending = 1'b0;
    end
    addr_char_q.push_back(e);
  endtask

  task automatic emit_digit(input logic [4:0] v);
    push_addr_char(digit_to_char(v), 1'b0);
    residue = bch_step(residue) ^ {25'd0, v};
  endtask

  // Expected characters caused by one program byte
  task automatic predict_address_chars(input logic [7:0] pbyte, input logic plast);
    int unsigned len;
    int unsigned nb;
    int unsigned i;
    logic [29:0] chk;
    logic [7:0]  c;
    logic [11:0] padded;
    // prefix, separator and version on the first byte of an address
    if (!msg_open) begin
      len = (pfx_len > PFX_MAX) ? PFX_MAX : pfx_len;
      chk = 30'd1;
      for (i = 0; i < len; i++) begin
        c   = pfx_chars[8*i +: 8];
        chk = bch_step(chk) ^ {27'd0, c[7:5]};
      end
      chk = bch_step(chk);
      for (i = 0; i < len; i++) begin
        c   = pfx_chars[8*i +: 8];
        chk = bch_step(chk) ^ {25'd0, c[4:0]};
        push_addr_char(c[6:0], 1'b0);
      end
      push_addr_char(b32enc_pkg::SEP_CHAR, 1'b0);
      residue = chk;
      emit_digit(5'd0);
      acc      = '0;
      nbits    = 0;
      msg_open = 1'b1;
    end
    // regroup into 5-bit digits
    acc = {acc[3:0], pbyte};
    nb  = nbits + 8;
    while (nb >= 5) begin
      nb = nb - 5;
      emit_digit(acc[nb +: 5]);
    end
    acc   = acc & ((12'd1 << nb) - 12'd1);
    nbits = nb;
    // pad, finish the checksum and send it
    if (plast) begin
      if (nb > 0) begin
        padded = acc << (5 - nb);
        emit_digit(padded[4:0]);
      end
      repeat (6) residue = bch_step(residue);
      residue = residue ^ 30'd1;
      for (i = 0; i < 6; i++) begin
        push_addr_char(digit_to_char(residue[5*(5-i) +: 5]), i == 5);
      end
      acc      = '0;
      nbits    = 0;
      residue  = 30'd1;
      msg_open = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check output transfers, predict on input transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    addr_char_t exp_c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (addr_char_q.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual char %h last %b",
                   $time, out_tdata, out_tlast);
          err_cnt++;
        end else begin
          exp_c = addr_char_q.pop_front();
          if (out_tdata[6:0] !== exp_c.ch) begin
            $display("%0t: out_char: expected %h, actual %h", $time, exp_c.ch,
                     out_tdata[6:0]);
            err_cnt++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $display("%0t: tdata pad bit: expected 0, actual %b", $time, out_tdata[7]);
            err_cnt++;
          end
          if (out_tlast !== exp_c.lst) begin
            $display("%0t: last_char: expected %b, actual %b", $time, exp_c.lst,
                     out_tlast);
            err_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_address_chars(in_tdata, in_tlast);
        sent_items++;
      end
    end
  end

  // Receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks
  // ---------------------------------------------------------------------------

  // Offer one byte with random leading gaps, return at its transfer
  task automatic send_byte(input logic [7:0] b, input logic lst,
                           input logic has_lead, input logic [6:0] lead);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    lead_pending = has_lead;
    lead_ch      = lead;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every expected character has come out
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (addr_char_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_PREFIX_CHARS) pfx_chars = val;
    else                         pfx_len   = val[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_write(input logic idx, input logic [63:0] val);
    dir_row_t r;
    r.kind = ROW_WRITE; r.idx = idx; r.data = val;
    r.lst = 1'b0; r.has_lead = 1'b0; r.lead = '0;
    dir_tbl.push_back(r);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic lst,
                          input logic has_lead, input logic [6:0] lead);
    dir_row_t r;
    r.kind = ROW_BYTE; r.idx = REG_PREFIX_CHARS; r.data = {56'd0, b};
    r.lst = lst; r.has_lead = has_lead; r.lead = lead;
    dir_tbl.push_back(r);
  endtask

  // Random prefix between addresses; lengths cover zero and saturation
  task automatic random_prefix();
    int unsigned pick;
    logic [63:0] chars;
    logic [3:0]  len;
    int unsigned k;
    pick = $urandom_range(9);
    if (pick == 0)      len = 4'd0;
    else if (pick == 1) len = 4'($urandom_range(15, 9));
    else                len = 4'($urandom_range(8, 1));
    if ($urandom_range(1) == 0) begin
      chars = {$urandom, $urandom};
    end else begin
      for (k = 0; k < 8; k++) chars[8*k +: 8] = 8'($urandom_range(122, 97));
    end
    drain_outputs();
    case ($urandom_range(2))
      0: write_reg(REG_PREFIX_CHARS, chars);
      1: write_reg(REG_PREFIX_LENGTH, {60'd0, len});
      default: begin
        write_reg(REG_PREFIX_CHARS, chars);
        write_reg(REG_PREFIX_LENGTH, {60'd0, len});
      end
    endcase
  endtask

  // One well-formed address: mostly short programs, some 20 and 32 bytes
  task automatic random_address();
    int unsigned pick;
    int unsigned nbytes;
    int unsigned k;
    logic [7:0]  b;
    pick = $urandom_range(19);
    if (pick < 15)       nbytes = $urandom_range(8, 1);
    else if (pick == 15) nbytes = 20;
    else if (pick == 16) nbytes = 32;
    else                 nbytes = $urandom_range(40, 1);
    for (k = 0; k < nbytes; k++) begin
      case ($urandom_range(9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, k == nbytes - 1, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned rand_base;
    int unsigned k;
    dir_row_t    r;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_PREFIX_CHARS;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    pfx_chars    = 64'h6362;
    pfx_len      = 4'd2;
    acc          = '0;
    nbits        = 0;
    residue      = 30'd1;
    msg_open     = 1'b0;
    lead_pending = 1'b0;
    lead_ch      = '0;
    tx_idle_pct  = 37;
    rx_idle_pct  = 62;
    hold_left    = 0;
    sent_items   = 0;
    err_cnt      = 0;
    cycle_cnt    = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset prefix, byte extremes, single-byte addresses
    add_byte(8'h00, 1'b0, 1'b1, 7'h62);
    add_byte(8'hFF, 1'b0, 1'b0, '0);
    add_byte(8'hA5, 1'b1, 1'b0, '0);
    add_byte(8'h00, 1'b1, 1'b1, 7'h62);
    add_byte(8'hFF, 1'b1, 1'b1, 7'h62);
    // empty prefix starts at the separator
    add_write(REG_PREFIX_LENGTH, 64'd0);
    add_byte(8'h5A, 1'b1, 1'b1, b32enc_pkg::SEP_CHAR);
    // prefix bytes with bit 7 set and zero bytes, length saturated
    add_write(REG_PREFIX_CHARS, 64'h4100_80FF_7F00_20C2);
    add_write(REG_PREFIX_LENGTH, 64'd15);
    add_byte(8'h12, 1'b0, 1'b1, 7'h42);
    // rewrite inside an address only affects the next one
    add_write(REG_PREFIX_CHARS, 64'h78);
    add_write(REG_PREFIX_LENGTH, 64'd1);
    add_byte(8'h34, 1'b0, 1'b0, '0);
    add_byte(8'hFE, 1'b1, 1'b0, '0);
    add_byte(8'h80, 1'b1, 1'b1, 7'h78);
    // full-length prefix, then one past the maximum
    add_write(REG_PREFIX_CHARS, 64'h6867_6665_6463_6261);
    add_write(REG_PREFIX_LENGTH, 64'd8);
    add_byte(8'h01, 1'b1, 1'b1, 7'h61);
    add_write(REG_PREFIX_LENGTH, 64'd9);
    // five bytes: every leftover count, no pad digit at the end
    add_byte(8'h00, 1'b0, 1'b1, 7'h61);
    add_byte(8'hFF, 1'b0, 1'b0, '0);
    add_byte(8'h55, 1'b0, 1'b0, '0);
    add_byte(8'hAA, 1'b0, 1'b0, '0);
    add_byte(8'h7F, 1'b1, 1'b0, '0);
    // back to the reset prefix
    add_write(REG_PREFIX_CHARS, 64'h6362);
    add_write(REG_PREFIX_LENGTH, 64'd2);

    for (k = 0; k < dir_tbl.size(); k++) begin
      r = dir_tbl[k];
      if (r.kind == ROW_WRITE) begin
        drain_outputs();
        write_reg(r.idx, r.data);
      end else begin
        send_byte(r.data[7:0], r.lst, r.has_lead, r.lead);
      end
    end

    // random addresses in three stall phases
    rand_base = sent_items;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 37; rx_idle_pct = 62; end
        1: begin tx_idle_pct = 62; rx_idle_pct = 37; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // long receiver hold-off while a full program is offered
          hold_left   = 600;
          for (k = 0; k < 32; k++) begin
            send_byte(8'($urandom_range(255)), k == 31, 1'b0, '0);
          end
        end
      endcase
      while (sent_items < rand_base + (ph + 1) * (RAND_ITEMS / 3)) begin
        if ($urandom_range(3) == 0) random_prefix();
        random_address();
      end
    end

    drain_outputs();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("bech32_address_encoder_unit: match");
    end else begin
      $display("bech32_address_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule
